@@ rtl/rlsd_pkg.sv @@
// Shared types and constants for the run-length sprite frame decoder.
`timescale 1ns / 1ps
package rlsd_pkg;

  localparam int LINES_PER_BLOCK = 32;
  localparam int BLOCK_COUNT     = 4;
  localparam int HDR_WORDS       = BLOCK_COUNT + 1;
  localparam int HDR_BYTES       = 2 * HDR_WORDS;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

  localparam logic [7:0]  MARKER_LO    = 8'h0A;
  localparam logic [7:0]  MARKER_HI    = 8'h00;
  localparam logic [7:0]  REPEAT_BASE  = 8'h80;
  localparam logic [7:0]  LITERAL_BASE = 8'hBF;
  localparam logic [8:0]  CODE_SPAN    = 9'd256;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;
  localparam logic [23:0] TOTAL_MAX    = 24'hFFFFFF;
  localparam logic [15:0] WIDTH_MAX    = 16'd2047;

  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_HEADER = 2'd1;
  localparam logic [1:0] ST_BAD_WIDTH = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  typedef enum logic [1:0] {
    MODE_CODE    = 2'd0,
    MODE_REPEAT  = 2'd1,
    MODE_LITERAL = 2'd2
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic        is_transparent;
    logic [7:0]  palette_index;
    logic [6:0]  run_length;
    logic [1:0]  frame_status;
    logic [10:0] frame_width;
    logic [23:0] pixel_total;
    logic        is_last;
  } out_item_t;

endpackage

@@ rtl/run_length_sprite_frame_decoder_core.sv @@
// Top level: byte-wise run-length sprite frame decoder with output queue.
`timescale 1ns / 1ps
// One frame byte is taken per cycle while in_stall is low. Header, code
// parsing, per-block pixel counting and the end-of-frame width check all
// settle in the cycle of the transfer; results are registered into a 4-entry
// output queue. A byte gives at most one run; the last byte of a frame adds a
// summary, so it queues up to two results. The queue drains one result per
// cycle while out_stall is low, and input stalls while fewer than two entries
// are free. Sustained rate: one byte per cycle while the output side keeps up.
module run_length_sprite_frame_decoder_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rlsd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rlsd_pkg::out_item_t  out_data
);
  import rlsd_pkg::*;

  logic [15:0]  pos_r, pos_nxt;
  logic [15:0]  offs_r [HDR_WORDS];
  logic [15:0]  offs_nxt [HDR_WORDS];
  parse_mode_t  mode_r, mode_nxt;
  logic [6:0]   lit_r, lit_nxt;
  logic [5:0]   rep_r, rep_nxt;
  logic [15:0]  cnt_r [BLOCK_COUNT];
  logic [15:0]  cnt_nxt [BLOCK_COUNT];
  logic [23:0]  total_r, total_nxt;
  logic         hdr_ok_r, hdr_ok_nxt;

  logic         accept;
  logic [7:0]   byte_in;
  logic         run_vld;
  logic         sum_vld;
  out_item_t    run_item;
  out_item_t    sum_item;
  logic         do_count;
  logic [6:0]   pix_n;
  logic [24:0]  total_sum;
  logic [15:0]  blk_w [BLOCK_COUNT];
  logic         alive;
  logic         mismatch;
  logic [15:0]  wid;
  logic [1:0]   status;

  out_item_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]       count_r, count_nxt;
  logic                   pop;
  logic [1:0]             n_push;
  out_item_t              push_a;

  assign accept    = in_valid && !in_stall;
  assign byte_in   = in_data.data_byte;
  assign in_stall  = (count_r > (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    pos_nxt    = pos_r;
    mode_nxt   = mode_r;
    lit_nxt    = lit_r;
    rep_nxt    = rep_r;
    total_nxt  = total_r;
    hdr_ok_nxt = hdr_ok_r;
    for (int w = 0; w < HDR_WORDS; w++) offs_nxt[w] = offs_r[w];
    for (int b = 0; b < BLOCK_COUNT; b++) cnt_nxt[b] = cnt_r[b];
    run_vld  = 1'b0;
    sum_vld  = 1'b0;
    run_item = '0;
    sum_item = '0;
    do_count = 1'b0;
    pix_n    = '0;
    total_sum = '0;
    alive    = 1'b1;
    mismatch = 1'b0;
    wid      = '0;
    status   = ST_OK;
    for (int i = 0; i < BLOCK_COUNT; i++) blk_w[i] = '0;

    if (accept) begin
      if (pos_r < 16'(HDR_BYTES)) begin
        for (int w = 0; w < HDR_WORDS; w++) begin
          if (pos_r == 16'(2 * w)) begin
            offs_nxt[w] = {8'h00, byte_in};
          end else if (pos_r == 16'(2 * w + 1)) begin
            offs_nxt[w] = {byte_in, offs_r[w][7:0]};
          end
        end
        if (pos_r == 16'd1) begin
          hdr_ok_nxt = (offs_r[0][7:0] == MARKER_LO) && (byte_in == MARKER_HI);
        end
      end else if (hdr_ok_r) begin
        unique case (mode_r)
          MODE_REPEAT: begin
            run_vld                 = 1'b1;
            run_item.palette_index  = byte_in;
            run_item.run_length     = {1'b0, rep_r};
            rep_nxt                 = '0;
            mode_nxt                = MODE_CODE;
          end
          MODE_LITERAL: begin
            run_vld                 = 1'b1;
            run_item.palette_index  = byte_in;
            run_item.run_length     = 7'd1;
            lit_nxt                 = lit_r - 7'd1;
            if (lit_r == 7'd1) mode_nxt = MODE_CODE;
          end
          default: begin
            priority if (byte_in >= LITERAL_BASE) begin
              lit_nxt  = 7'(CODE_SPAN - {1'b0, byte_in});
              pix_n    = lit_nxt;
              do_count = 1'b1;
              mode_nxt = MODE_LITERAL;
            end else if (byte_in >= REPEAT_BASE) begin
              rep_nxt  = 6'(LITERAL_BASE - byte_in);
              pix_n    = {1'b0, rep_nxt};
              do_count = 1'b1;
              mode_nxt = MODE_REPEAT;
            end else if (byte_in != 8'h00) begin
              pix_n                   = byte_in[6:0];
              do_count                = 1'b1;
              run_vld                 = 1'b1;
              run_item.is_transparent = 1'b1;
              run_item.run_length     = byte_in[6:0];
            end
          end
        endcase
      end

      if (do_count) begin
        for (int b = 0; b < BLOCK_COUNT; b++) begin
          if (offs_r[b] <= pos_r && pos_r < offs_r[b+1]) begin
            cnt_nxt[b] = cnt_r[b] + 16'(pix_n);
          end
        end
      end

      if (run_vld) begin
        total_sum = {1'b0, total_r} + 25'(run_item.run_length);
        total_nxt = total_sum[24] ? TOTAL_MAX : total_sum[23:0];
      end

      if (pos_r != POS_MAX) pos_nxt = pos_r + 16'd1;

      if (in_data.frame_end) begin
        for (int i = 0; i < BLOCK_COUNT; i++) begin
          if (offs_nxt[i+1] == '0) alive = 1'b0;
          if (alive) blk_w[i] = 16'(cnt_nxt[i] / LINES_PER_BLOCK);
        end
        for (int i = 0; i + 1 < BLOCK_COUNT; i++) begin
          if (blk_w[i+1] != '0 && blk_w[i] != blk_w[i+1]) mismatch = 1'b1;
        end
        wid = mismatch ? '0 : blk_w[0];

        priority if (pos_nxt < 16'(HDR_BYTES) || !hdr_ok_nxt) begin
          status = ST_NO_HEADER;
          wid    = '0;
        end else if (wid == '0 || wid > WIDTH_MAX) begin
          status = ST_BAD_WIDTH;
          wid    = '0;
        end else if (mode_nxt != MODE_CODE) begin
          status = ST_TRUNCATED;
        end else begin
          status = ST_OK;
        end

        sum_vld               = 1'b1;
        sum_item.item_kind    = KIND_SUMMARY;
        sum_item.frame_status = status;
        sum_item.frame_width  = wid[10:0];
        sum_item.pixel_total  = total_nxt;
        sum_item.is_last      = 1'b1;

        pos_nxt    = '0;
        mode_nxt   = MODE_CODE;
        lit_nxt    = '0;
        rep_nxt    = '0;
        total_nxt  = '0;
        hdr_ok_nxt = 1'b0;
        for (int w = 0; w < HDR_WORDS; w++) offs_nxt[w] = '0;
        for (int b = 0; b < BLOCK_COUNT; b++) cnt_nxt[b] = '0;
      end
    end
    run_item.item_kind = KIND_RUN;
  end

  assign n_push    = {1'b0, run_vld} + {1'b0, sum_vld};
  assign push_a    = run_vld ? run_item : sum_item;
  assign count_nxt = count_r + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      mode_r   <= MODE_CODE;
      lit_r    <= '0;
      rep_r    <= '0;
      total_r  <= '0;
      hdr_ok_r <= 1'b0;
      for (int w = 0; w < HDR_WORDS; w++) offs_r[w] <= '0;
      for (int b = 0; b < BLOCK_COUNT; b++) cnt_r[b] <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      pos_r    <= pos_nxt;
      mode_r   <= mode_nxt;
      lit_r    <= lit_nxt;
      rep_r    <= rep_nxt;
      total_r  <= total_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      for (int w = 0; w < HDR_WORDS; w++) offs_r[w] <= offs_nxt[w];
      for (int b = 0; b < BLOCK_COUNT; b++) cnt_r[b] <= cnt_nxt[b];
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(n_push);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) fifo_r[wr_ptr_r] <= push_a;
    if (n_push == 2'd2) fifo_r[wr_ptr_r + FIFO_AW'(1)] <= sum_item;
  end

endmodule
